// ===== design/aes_pkg.sv =====
package aes_pkg;

  localparam int Rounds = 10;

  typedef logic [127:0] blk_t;

  typedef enum logic {
    OP_ENC = 1'b0,
    OP_DEC = 1'b1
  } op_t;

  typedef enum logic {
    REG_KEY_HIGH = 1'b0,
    REG_KEY_LOW  = 1'b1
  } reg_idx_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] ISBOX [256] = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
  };

  localparam logic [7:0] RCON [10] = '{
    8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1b,8'h36
  };

  function automatic logic [7:0] xt(input logic [7:0] a);
    xt = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  // byte n of a block sits at bits [127-8n -: 8]
  function automatic logic [7:0] bget(input blk_t s, input int n);
    bget = s[127 - 8 * n -: 8];
  endfunction

  function automatic blk_t sub_bytes(input blk_t s, input logic inv);
    blk_t t;
    for (int n = 0; n < 16; n++) begin
      t[127 - 8 * n -: 8] = inv ? ISBOX[bget(s, n)] : SBOX[bget(s, n)];
    end
    sub_bytes = t;
  endfunction

  function automatic blk_t shift_rows(input blk_t s, input logic inv);
    blk_t t;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        if (inv) begin
          t[127 - 8 * (((c + r) % 4) * 4 + r) -: 8] = bget(s, c * 4 + r);
        end else begin
          t[127 - 8 * (c * 4 + r) -: 8] = bget(s, ((c + r) % 4) * 4 + r);
        end
      end
    end
    shift_rows = t;
  endfunction

  function automatic blk_t mix_cols(input blk_t s, input logic inv);
    blk_t t;
    logic [7:0] a0, a1, a2, a3, x0, x1, x2, x3, y0, y2, z0, z1, z2, z3;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        a0 = bget(s, c * 4 + r);
        a1 = bget(s, c * 4 + (r + 1) % 4);
        a2 = bget(s, c * 4 + (r + 2) % 4);
        a3 = bget(s, c * 4 + (r + 3) % 4);
        x0 = xt(a0); x1 = xt(a1); x2 = xt(a2); x3 = xt(a3);
        y0 = xt(x0); y2 = xt(x2);
        z0 = xt(y0); z1 = xt(xt(x1)); z2 = xt(y2); z3 = xt(xt(x3));
        if (inv) begin
          // 14,11,13,9
          t[127 - 8 * (c * 4 + r) -: 8] = (z0 ^ y0 ^ x0) ^ (z1 ^ x1 ^ a1)
            ^ (z2 ^ y2 ^ a2) ^ (z3 ^ a3);
        end else begin
          t[127 - 8 * (c * 4 + r) -: 8] = x0 ^ x1 ^ a1 ^ a2 ^ a3;
        end
      end
    end
    mix_cols = t;
  endfunction

  function automatic blk_t next_rkey(input blk_t k, input logic [7:0] rc);
    logic [31:0] w0, w1, w2, w3, t;
    w0 = k[127:96]; w1 = k[95:64]; w2 = k[63:32]; w3 = k[31:0];
    t = {SBOX[w3[23:16]] ^ rc, SBOX[w3[15:8]], SBOX[w3[7:0]], SBOX[w3[31:24]]};
    w0 = w0 ^ t; w1 = w1 ^ w0; w2 = w2 ^ w1; w3 = w3 ^ w2;
    next_rkey = {w0, w1, w2, w3};
  endfunction

endpackage

// ===== design/aes128_block_cipher.sv =====
// pipeline: add-key stage plus 10 round stages, then an output register
// throughput: one block per cycle unless stalled; one round per stage, each with own s-box tables
// a stall holds only valid stages; empty stages still load, so bubbles are squeezed out
// reset: synchronous, clears all valid bits and both key registers to zero
// round keys are expanded one round per cycle; input is stalled after reset
// and after each key write while the round key pipeline settles
module aes128_block_cipher import aes_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        op,
  input  logic [63:0] block_high,
  input  logic [63:0] block_low,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] result_high,
  output logic [63:0] result_low
);

  logic [63:0] key_high;
  logic [63:0] key_low;
  blk_t        rkey [Rounds + 1];
  logic [3:0]  key_wait;

  blk_t        st  [Rounds + 1];
  logic        sop [Rounds + 1];
  logic        sv  [Rounds + 1];
  blk_t        out_blk;
  logic        advance [Rounds + 2];

  always_ff @(posedge clk) begin
    if (rst) begin
      key_high <= '0;
      key_low  <= '0;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_KEY_HIGH: key_high <= cfg_data;
        REG_KEY_LOW:  key_low  <= cfg_data;
        default: ;
      endcase
    end
  end

  // key_wait stalls input until every round key register has settled after a key change
  always_ff @(posedge clk) begin
    if (rst || cfg_we) begin
      key_wait <= 4'(Rounds);
    end else if (key_wait != 4'd0) begin
      key_wait <= key_wait - 4'd1;
    end
  end

  assign rkey[0] = {key_high, key_low};

  for (genvar k = 1; k <= Rounds; k++) begin : g_key
    always_ff @(posedge clk) begin
      rkey[k] <= next_rkey(rkey[k - 1], RCON[k - 1]);
    end
  end

  // advance[i]: stage i may load; stage Rounds+1 is the output register
  always_comb begin
    advance[Rounds + 1] = !out_valid || !out_stall;
    for (int i = Rounds; i >= 0; i--) begin
      advance[i] = !sv[i] || advance[i + 1];
    end
  end

  assign in_stall = !advance[0] || (key_wait != 4'd0);

  // stage 0: initial add round key
  always_ff @(posedge clk) begin
    if (rst) begin
      sv[0] <= 1'b0;
    end else if (!in_stall) begin
      sv[0] <= in_valid;
    end else if (advance[0]) begin
      sv[0] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      sop[0] <= op;
      st[0]  <= {block_high, block_low} ^ (op ? rkey[Rounds] : rkey[0]);
    end
  end

  for (genvar g = 1; g <= Rounds; g++) begin : g_round
    blk_t enc_v, dec_v, sd;
    always_comb begin
      enc_v = shift_rows(sub_bytes(st[g - 1], 1'b0), 1'b0);
      if (g != Rounds) begin
        enc_v = mix_cols(enc_v, 1'b0);
      end
      enc_v = enc_v ^ rkey[g];
      sd = sub_bytes(shift_rows(st[g - 1], 1'b1), 1'b1) ^ rkey[Rounds - g];
      dec_v = (g != Rounds) ? mix_cols(sd, 1'b1) : sd;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        sv[g] <= 1'b0;
      end else if (advance[g]) begin
        sv[g] <= sv[g - 1];
      end
    end

    always_ff @(posedge clk) begin
      if (advance[g] && sv[g - 1]) begin
        sop[g] <= sop[g - 1];
        st[g]  <= sop[g - 1] ? dec_v : enc_v;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance[Rounds + 1]) begin
      out_valid <= sv[Rounds];
    end
  end

  always_ff @(posedge clk) begin
    if (advance[Rounds + 1] && sv[Rounds]) begin
      out_blk <= st[Rounds];
    end
  end

  assign result_high = out_blk[127:64];
  assign result_low  = out_blk[63:0];

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_blk))
    else $error("result changed under stall");

  a_no_stall_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid && key_wait == 4'd0 |-> !in_stall)
    else $error("input stalled with empty output");

  a_key_settling: assert property (@(posedge clk) disable iff (rst)
    key_wait != 4'd0 |-> in_stall)
    else $error("request accepted before round keys settled");

  a_last_moves: assert property (@(posedge clk) disable iff (rst)
    sv[Rounds] && !out_stall |=> out_valid)
    else $error("final stage result lost");

endmodule

// ===== bench/tb.sv =====
module tb;
  import aes_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int IdleLimit = 20000;
  localparam int RandomBlocks = 2000;

  typedef struct {
    op_t         op;
    logic [63:0] blk_hi;
    logic [63:0] blk_lo;
    logic        known;
    logic [63:0] want_hi;
    logic [63:0] want_lo;
  } vec_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [63:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        op = 1'b0;
  logic [63:0] block_high = '0;
  logic [63:0] block_low = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [63:0] result_high;
  logic [63:0] result_low;

  logic [63:0] key_hi_q, key_lo_q;
  blk_t        cipher_q[$];
  int          mismatches = 0;
  int          idle_cycles = 0;

  aes128_block_cipher dut (.*);

  always #2 clk = ~clk;

  // field arithmetic for the predictor
  function automatic logic [7:0] gf_dbl(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] p;
    p = 8'h00;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) p ^= a;
      a = gf_dbl(a);
    end
    return p;
  endfunction

  function automatic logic [7:0] gf_inv(input logic [7:0] a);
    logic [7:0] p, r;
    p = a;
    r = 8'h01;
    for (int i = 1; i < 8; i++) begin
      p = gf_mul(p, p);
      r = gf_mul(r, p);
    end
    return (a == 8'h00) ? 8'h00 : r;
  endfunction

  function automatic logic [7:0] rotl(input logic [7:0] x, input int n);
    return (x << n) | (x >> (8 - n));
  endfunction

  function automatic logic [7:0] sub_fwd(input logic [7:0] x);
    logic [7:0] b;
    b = gf_inv(x);
    return b ^ rotl(b, 1) ^ rotl(b, 2) ^ rotl(b, 3) ^ rotl(b, 4) ^ 8'h63;
  endfunction

  function automatic logic [7:0] sub_inv(input logic [7:0] x);
    return gf_inv(rotl(x, 1) ^ rotl(x, 3) ^ rotl(x, 6) ^ 8'h05);
  endfunction

  function automatic blk_t aes_cipher(input op_t dir, input blk_t blk,
                                      input logic [63:0] kh, input logic [63:0] kl);
    logic [7:0] rk[176];
    logic [7:0] s[16];
    logic [7:0] t[16];
    logic [7:0] w[4];
    logic [7:0] a[4];
    logic [7:0] rc, f;
    blk_t res;
    int o;
    rc = 8'h01;
    for (int i = 0; i < 8; i++) begin
      rk[i] = kh[63 - 8 * i -: 8];
      rk[8 + i] = kl[63 - 8 * i -: 8];
    end
    for (int i = 4; i < 44; i++) begin
      for (int j = 0; j < 4; j++) w[j] = rk[(i - 1) * 4 + j];
      if (i % 4 == 0) begin
        f = w[0];
        w[0] = sub_fwd(w[1]) ^ rc;
        w[1] = sub_fwd(w[2]);
        w[2] = sub_fwd(w[3]);
        w[3] = sub_fwd(f);
        rc = gf_dbl(rc);
      end
      for (int j = 0; j < 4; j++) rk[i * 4 + j] = rk[(i - 4) * 4 + j] ^ w[j];
    end
    for (int n = 0; n < 16; n++) s[n] = blk[127 - 8 * n -: 8];
    for (int k = 0; k < 11; k++) begin
      int rnd;
      rnd = (dir == OP_ENC) ? k : 10 - k;
      if (k > 0) begin
        for (int c = 0; c < 4; c++) begin
          for (int r = 0; r < 4; r++) begin
            o = ((c + r) % 4) * 4 + r;
            if (dir == OP_DEC) t[o] = s[c * 4 + r];
            else t[c * 4 + r] = s[o];
          end
        end
        for (int n = 0; n < 16; n++) s[n] = (dir == OP_DEC) ? sub_inv(t[n]) : sub_fwd(t[n]);
        if (dir == OP_ENC && k < 10) begin
          for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) a[r] = s[c * 4 + r];
            for (int r = 0; r < 4; r++) begin
              s[c * 4 + r] = gf_dbl(a[r]) ^ gf_dbl(a[(r + 1) % 4]) ^ a[(r + 1) % 4]
                ^ a[(r + 2) % 4] ^ a[(r + 3) % 4];
            end
          end
        end
      end
      for (int n = 0; n < 16; n++) s[n] ^= rk[rnd * 16 + n];
      if (dir == OP_DEC && k > 0 && k < 10) begin
        for (int c = 0; c < 4; c++) begin
          for (int r = 0; r < 4; r++) a[r] = s[c * 4 + r];
          for (int r = 0; r < 4; r++) begin
            s[c * 4 + r] = gf_mul(a[r], 8'd14) ^ gf_mul(a[(r + 1) % 4], 8'd11)
              ^ gf_mul(a[(r + 2) % 4], 8'd13) ^ gf_mul(a[(r + 3) % 4], 8'd9);
          end
        end
      end
    end
    for (int n = 0; n < 16; n++) res[127 - 8 * n -: 8] = s[n];
    return res;
  endfunction

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  task automatic write_key(input reg_idx_t idx, input logic [63:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_KEY_HIGH) key_hi_q = val;
    else key_lo_q = val;
    @(negedge clk);
  endtask

  task automatic send_block(input vec_t v);
    blk_t want;
    op <= v.op;
    block_high <= v.blk_hi;
    block_low <= v.blk_lo;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    want = v.known ? {v.want_hi, v.want_lo}
                   : aes_cipher(v.op, {v.blk_hi, v.blk_lo}, key_hi_q, key_lo_q);
    cipher_q.push_back(want);
    @(negedge clk);
    if ($urandom_range(0, 3) != 0) begin
      int g;
      g = gap_len();
      if (g > 0) begin
        in_valid <= 1'b0;
        repeat (g) @(negedge clk);
      end
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (cipher_q.size() != 0) @(negedge clk);
    repeat (16) @(negedge clk);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // receiver stall pattern, sampled at posedge and driven at negedge
  initial begin
    int g;
    forever begin
      @(negedge clk);
      if ($urandom_range(0, 3) == 0) begin
        g = gap_len();
        if (g > 0) begin
          out_stall <= 1'b1;
          repeat (g) @(negedge clk);
          out_stall <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    blk_t want;
    if (rst) begin
      idle_cycles <= 0;
    end else begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (out_valid && !out_stall) begin
        if (cipher_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %h %h", result_high, result_low);
        end else begin
          want = cipher_q.pop_front();
          if (result_high !== want[127:64] || result_low !== want[63:0]) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("result mismatch: want %h %h got %h %h",
                       want[127:64], want[63:0], result_high, result_low);
            end
          end
        end
      end
      if (idle_cycles >= IdleLimit) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  initial begin
    vec_t dir_tab[$];
    vec_t v;
    logic [63:0] keys[4][2];
    key_hi_q = '0;
    key_lo_q = '0;
    repeat (11) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: known-answer vectors plus extremes under reset key, then the fips-197 key and vectors
    dir_tab.push_back('{OP_ENC, 64'h0, 64'h0, 1'b1, 64'h66e94bd4ef8a2c3b, 64'h884cfa59ca342b2e});
    dir_tab.push_back('{OP_DEC, 64'h66e94bd4ef8a2c3b, 64'h884cfa59ca342b2e, 1'b1, 64'h0, 64'h0});
    dir_tab.push_back('{OP_ENC, '1, '1, 1'b0, '0, '0});
    dir_tab.push_back('{OP_DEC, '1, '1, 1'b0, '0, '0});
    dir_tab.push_back('{OP_DEC, 64'h0, 64'h0, 1'b0, '0, '0});
    dir_tab.push_back('{OP_ENC, 64'h8000000000000000, 64'h1, 1'b0, '0, '0});
    foreach (dir_tab[i]) send_block(dir_tab[i]);
    drain();

    write_key(REG_KEY_HIGH, 64'h0001020304050607);
    write_key(REG_KEY_LOW, 64'h08090a0b0c0d0e0f);
    dir_tab.delete();
    dir_tab.push_back('{OP_ENC, 64'h0011223344556677, 64'h8899aabbccddeeff, 1'b1,
                        64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a});
    dir_tab.push_back('{OP_DEC, 64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a, 1'b1,
                        64'h0011223344556677, 64'h8899aabbccddeeff});
    dir_tab.push_back('{OP_ENC, '1, 64'h0, 1'b0, '0, '0});
    dir_tab.push_back('{OP_DEC, 64'h0, '1, 1'b0, '0, '0});
    foreach (dir_tab[i]) send_block(dir_tab[i]);
    drain();

    keys[0] = '{'1, '1};
    keys[1] = '{64'h2b7e151628aed2a6, 64'habf7158809cf4f3c};
    keys[2] = '{64'h0, 64'h1};
    keys[3] = '{rand64(), rand64()};
    for (int ph = 0; ph < 5; ph++) begin
      if (ph < 4) begin
        write_key(REG_KEY_HIGH, keys[ph][0]);
        write_key(REG_KEY_LOW, keys[ph][1]);
      end else begin
        write_key(REG_KEY_LOW, rand64());
        write_key(REG_KEY_HIGH, rand64());
      end
      for (int i = 0; i < RandomBlocks / 5; i++) begin
        v.op = op_t'($urandom_range(0, 1));
        case ($urandom_range(0, 9))
          0: begin
            v.blk_hi = '1;
            v.blk_lo = rand64();
          end
          1: begin
            v.blk_hi = rand64();
            v.blk_lo = '0;
          end
          default: begin
            v.blk_hi = rand64();
            v.blk_lo = rand64();
          end
        endcase
        v.known = 1'b0;
        send_block(v);
      end
      drain();
    end

    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/aes_pkg.sv
design/aes128_block_cipher.sv
bench/tb.sv
